>>> sv/multiplexed_display_clock_with_keys_macros.svh
// Assertion macros for the display clock block.
// Used by files that assert; expects clk_i and rst_ni in scope.
`ifndef MULTIPLEXED_DISPLAY_CLOCK_WITH_KEYS_MACROS_SVH
`define MULTIPLEXED_DISPLAY_CLOCK_WITH_KEYS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MDCK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MDCK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mdck_pkg.sv
// Shared types, constants and decode functions for the display clock.
// No dependencies; the top, timekeeper and digit mux import it.
package mdck_pkg;

  localparam int unsigned NumDigits = 6;

  localparam logic [15:0] TicksPerSecondReset = 16'd1024;
  localparam logic [4:0]  HoursReset          = 5'd23;
  localparam logic [4:0]  HoursMax            = 5'd23;
  localparam logic [5:0]  MinSecMax           = 6'd59;

  localparam logic [2:0] PosSecUnits  = 3'd0;
  localparam logic [2:0] PosSecTens   = 3'd1;
  localparam logic [2:0] PosMinUnits  = 3'd2;
  localparam logic [2:0] PosMinTens   = 3'd3;
  localparam logic [2:0] PosHourUnits = 3'd4;
  localparam logic [2:0] PosHourTens  = 3'd5;

  // key combinations seen at the end of a frame
  localparam logic [5:0] KeyHoursUp   = 6'h21;
  localparam logic [5:0] KeyHoursDown = 6'h22;
  localparam logic [5:0] KeyMinUp     = 6'h11;
  localparam logic [5:0] KeyMinDown   = 6'h12;
  localparam logic [5:0] KeySecUp     = 6'h05;
  localparam logic [5:0] KeySecDown   = 6'h06;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [2:0] pos;
  } mdck_state_t;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       pulse;
  } mdck_step_t;

  typedef struct packed {
    logic [5:0] strobe;
    logic [6:0] segment;
  } mdck_disp_t;

  typedef struct packed {
    logic [5:0] digit_strobe;
    logic [6:0] segment_pattern;
    logic [4:0] hours_now;
    logic [5:0] minutes_now;
    logic [5:0] seconds_now;
    logic       second_pulse;
  } mdck_result_t;

  // tens digit of a value below 64: multiply by 13/128
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [9:0] p;
    p = 10'(v) * 10'd13;
    return {1'b0, p[9:7]};
  endfunction

  function automatic logic [3:0] units_of(input logic [5:0] v);
    logic [5:0] t10;
    logic [5:0] u;
    t10 = 6'(tens_of(v)) * 6'd10;
    u   = v - t10;
    return u[3:0];
  endfunction

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'b0111111;
      4'd1:    s = 7'b0000110;
      4'd2:    s = 7'b1011011;
      4'd3:    s = 7'b1001111;
      4'd4:    s = 7'b1100110;
      4'd5:    s = 7'b1101101;
      4'd6:    s = 7'b1111101;
      4'd7:    s = 7'b0000111;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1101111;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

endpackage

>>> sv/mdck_in_if.sv
// Tick input channel: valid/ready plus the key-sense bit.
// Depends on nothing.
interface mdck_in_if;
  logic valid;
  logic ready;
  logic key_sense;

  modport source (output valid, output key_sense, input ready);
  modport sink   (input valid, input key_sense, output ready);
endinterface

>>> sv/mdck_out_if.sv
// Result channel: valid/ready plus strobe, segments and time fields.
// Depends on nothing.
interface mdck_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] digit_strobe;
  logic [6:0] segment_pattern;
  logic [4:0] hours_now;
  logic [5:0] minutes_now;
  logic [5:0] seconds_now;
  logic       second_pulse;

  modport source (output valid, output digit_strobe, output segment_pattern,
                  output hours_now, output minutes_now, output seconds_now,
                  output second_pulse, input ready);
  modport sink   (input valid, input digit_strobe, input segment_pattern,
                  input hours_now, input minutes_now, input seconds_now,
                  input second_pulse, output ready);
endinterface

>>> sv/mdck_cfg_if.sv
// Configuration write channel: valid/ready plus the ticks-per-second word.
// Depends on nothing.
interface mdck_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/multiplexed_display_clock_with_keys.sv
// Multiplexed six-digit display clock with scanned keys: top level.
// Path: a tick word passes through the input reg, then the result reg.
// Throughput: one tick word per cycle while out_o.ready holds; one more tick is taken while a result word waits.
// Reset: async active low; time 23:00:00, tick/scan/history zero, 1024 ticks/s.
// Depends on mdck_pkg, mdck_*_if, mdck_timekeeper, mdck_digit_mux, macros header.
module multiplexed_display_clock_with_keys (
  input  logic        clk_i,
  input  logic        rst_ni,
  mdck_in_if.sink     in_i,
  mdck_cfg_if.sink    cfg_i,
  mdck_out_if.source  out_o
);
  import mdck_pkg::*;
  `include "multiplexed_display_clock_with_keys_macros.svh"

  // ticks-per-second register; always ready; the user must write it only while idle, the block does not enforce this
  logic [15:0] tps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TicksPerSecondReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      tps_q <= cfg_i.data;
    end
  end

  assign cfg_i.ready = 1'b1;

  // input register: holds one tick word until the state step fires
  logic in_valid_q;
  logic in_key_q;
  logic out_valid_q;
  mdck_result_t out_q, out_d;
  logic advance;

  // a held tick steps the clock whenever the result register is free or drains
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_key_q <= in_i.key_sense;
    end
  end

  mdck_state_t state;
  mdck_step_t  step;
  mdck_disp_t  disp;

  // digit decode reads the time as it stands before this tick
  mdck_digit_mux u_digit_mux (
    .state_i (state),
    .disp_o  (disp)
  );

  mdck_timekeeper u_timekeeper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .key_i    (in_key_q),
    .tps_i    (tps_q),
    .strobe_i (disp.strobe),
    .state_o  (state),
    .step_o   (step)
  );

  assign out_d.digit_strobe    = disp.strobe;
  assign out_d.segment_pattern = disp.segment;
  assign out_d.hours_now       = step.hours;
  assign out_d.minutes_now     = step.minutes;
  assign out_d.seconds_now     = step.seconds;
  assign out_d.second_pulse    = step.pulse;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.digit_strobe    = out_q.digit_strobe;
  assign out_o.segment_pattern = out_q.segment_pattern;
  assign out_o.hours_now       = out_q.hours_now;
  assign out_o.minutes_now     = out_q.minutes_now;
  assign out_o.seconds_now     = out_q.seconds_now;
  assign out_o.second_pulse    = out_q.second_pulse;

  // time fields of the held result within hh:mm:ss range
  logic time_ok;
  assign time_ok = (out_q.hours_now <= HoursMax) && (out_q.minutes_now <= MinSecMax) &&
                   (out_q.seconds_now <= MinSecMax);

  `MDCK_ASSERT_NEXT(a_step_gives_word, advance, out_valid_q, "step did not produce a word")
  `MDCK_ASSERT_NOW(a_strobe_onehot, out_valid_q, $onehot(out_q.digit_strobe), "strobe not one-hot")
  `MDCK_ASSERT_NOW(a_time_range, out_valid_q, time_ok, "time out of range")
  `MDCK_ASSERT_NEXT(a_held_tick_kept, in_valid_q && out_valid_q && !out_o.ready, in_valid_q, "held tick dropped")

endmodule

>>> sv/mdck_digit_mux.sv
// Digit select and seven-segment decode for the current scan position.
// Depends on mdck_pkg.
module mdck_digit_mux (
  input  mdck_pkg::mdck_state_t state_i,
  output mdck_pkg::mdck_disp_t  disp_o
);
  import mdck_pkg::*;

  logic [2:0] pos;
  logic [3:0] digit;

  // out-of-range position shows the seconds units digit
  assign pos = (state_i.pos < 3'(NumDigits)) ? state_i.pos : PosSecUnits;

  always_comb begin
    unique case (pos)
      PosSecUnits:  digit = units_of(state_i.seconds);
      PosSecTens:   digit = tens_of(state_i.seconds);
      PosMinUnits:  digit = units_of(state_i.minutes);
      PosMinTens:   digit = tens_of(state_i.minutes);
      PosHourUnits: digit = units_of({1'b0, state_i.hours});
      default:      digit = tens_of({1'b0, state_i.hours});
    endcase
  end

  assign disp_o.strobe  = 6'(1) << pos;
  assign disp_o.segment = seg_of(digit);

endmodule

>>> sv/mdck_timekeeper.sv
// Clock state: tick counter, hh:mm:ss, scan position, key scan and history.
// Depends on mdck_pkg.
module mdck_timekeeper (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  key_i,
  input  logic [15:0]           tps_i,
  input  logic [5:0]            strobe_i,
  output mdck_pkg::mdck_state_t state_o,
  output mdck_pkg::mdck_step_t  step_o
);
  import mdck_pkg::*;

  logic [15:0] tick_q, tick_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic [2:0]  pos_q, pos_d;
  logic [5:0]  scan_q, scan_d;
  logic [5:0]  hist_q [3];
  logic [5:0]  hist_d [3];

  logic [2:0]  pos;
  logic        frame_end;
  logic [5:0]  word;
  logic        fresh;
  logic [5:0]  sec_k, min_k;
  logic [4:0]  hour_k;
  logic [15:0] tick_inc;
  logic        pulse;

  assign pos       = (pos_q < 3'(NumDigits)) ? pos_q : PosSecUnits;
  assign frame_end = (pos == PosHourTens);
  assign word      = key_i ? (scan_q | strobe_i) : scan_q;
  assign fresh     = (word != hist_q[0]) && (word != hist_q[1]) && (word != hist_q[2]);

  // key step at frame end: wraps, no carry
  always_comb begin
    sec_k  = sec_q;
    min_k  = min_q;
    hour_k = hour_q;
    if (frame_end && fresh) begin
      unique case (word)
        KeyHoursUp:   hour_k = (hour_q >= HoursMax) ? 5'd0 : hour_q + 5'd1;
        KeyHoursDown: hour_k = (hour_q == 5'd0) ? HoursMax : hour_q - 5'd1;
        KeyMinUp:     min_k  = (min_q >= MinSecMax) ? 6'd0 : min_q + 6'd1;
        KeyMinDown:   min_k  = (min_q == 6'd0) ? MinSecMax : min_q - 6'd1;
        KeySecUp:     sec_k  = (sec_q >= MinSecMax) ? 6'd0 : sec_q + 6'd1;
        KeySecDown:   sec_k  = (sec_q == 6'd0) ? MinSecMax : sec_q - 6'd1;
        default: ;
      endcase
    end
  end

  assign tick_inc = tick_q + 16'd1;
  assign pulse    = (tick_inc >= tps_i);

  // second advance with carry, after the key step
  always_comb begin
    sec_d  = sec_k;
    min_d  = min_k;
    hour_d = hour_k;
    tick_d = pulse ? 16'd0 : tick_inc;
    if (pulse) begin
      if (sec_k >= MinSecMax) begin
        sec_d = 6'd0;
        if (min_k >= MinSecMax) begin
          min_d  = 6'd0;
          hour_d = (hour_k >= HoursMax) ? 5'd0 : hour_k + 5'd1;
        end else begin
          min_d = min_k + 6'd1;
        end
      end else begin
        sec_d = sec_k + 6'd1;
      end
    end
  end

  always_comb begin
    hist_d = hist_q;
    if (frame_end) begin
      pos_d     = PosSecUnits;
      scan_d    = 6'd0;
      hist_d[2] = hist_q[1];
      hist_d[1] = hist_q[0];
      hist_d[0] = word;
    end else begin
      pos_d  = pos + 3'd1;
      scan_d = word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= 16'd0;
      sec_q   <= 6'd0;
      min_q   <= 6'd0;
      hour_q  <= HoursReset;
      pos_q   <= PosSecUnits;
      scan_q  <= 6'd0;
      hist_q[0] <= 6'd0;
      hist_q[1] <= 6'd0;
      hist_q[2] <= 6'd0;
    end else if (step_i) begin
      tick_q  <= tick_d;
      sec_q   <= sec_d;
      min_q   <= min_d;
      hour_q  <= hour_d;
      pos_q   <= pos_d;
      scan_q  <= scan_d;
      hist_q  <= hist_d;
    end
  end

  assign state_o.hours   = hour_q;
  assign state_o.minutes = min_q;
  assign state_o.seconds = sec_q;
  assign state_o.pos     = pos_q;

  assign step_o.hours   = hour_d;
  assign step_o.minutes = min_d;
  assign step_o.seconds = sec_d;
  assign step_o.pulse   = pulse;

endmodule
